>>> rtl/core/cpd_pkg.sv
// Shared types and constants for the column post drawer.
`timescale 1ns / 1ps
package cpd_pkg;

  // Screen geometry defaults
  localparam int CpdScreenWidth  = 320;
  localparam int CpdScreenHeight = 200;

  // Field widths
  localparam int ColW  = 9;
  localparam int ByteW = 8;
  localparam int RowW  = 9;
  localparam int AddrW = 16;
  localparam int OrgW  = 16;
  localparam int PicWW = 9;
  localparam int PicHW = 8;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_PIC_WIDTH = 3'd2,
    REG_PIC_HEIGHT = 3'd3,
    REG_MIRROR    = 3'd4
  } cfg_reg_t;

  // Post stream terminator
  localparam logic [ByteW-1:0] TermByte = 8'hff;

  // Configuration register set
  typedef struct packed {
    logic [OrgW-1:0]  origin_x;
    logic [OrgW-1:0]  origin_y;
    logic [PicWW-1:0] picture_width;
    logic [PicHW-1:0] picture_height;
    logic             mirror_enable;
  } cpd_cfg_t;

  // Parsed item handed from the parser to the address stage
  typedef struct packed {
    logic             is_pix;
    logic             is_done;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [ByteW-1:0] data;
  } cpd_tok_t;

endpackage

>>> rtl/core/cpd_parser.sv
// Post stream parser with the input register of the pipeline.
`timescale 1ns / 1ps
module cpd_parser
  import cpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             load,
  input  logic [ColW-1:0]  source_column,
  input  logic [ByteW-1:0] data_byte,
  output logic             tok_valid,
  output cpd_tok_t         tok
);

  typedef enum logic [2:0] {
    PH_TOP  = 3'd0,
    PH_LEN  = 3'd1,
    PH_PAD1 = 3'd2,
    PH_PIX  = 3'd3,
    PH_PAD2 = 3'd4
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [RowW-1:0]  row_r, row_nxt;
  logic [ByteW-1:0] left_r, left_nxt;
  logic             tok_valid_r;
  cpd_tok_t         tok_r, tok_nxt;

  // Advance the parser for one accepted byte
  always_comb begin
    phase_nxt       = phase_r;
    row_nxt         = row_r;
    left_nxt        = left_r;
    tok_nxt.is_pix  = 1'b0;
    tok_nxt.is_done = 1'b0;
    tok_nxt.row     = row_r;
    tok_nxt.col     = source_column;
    tok_nxt.data    = data_byte;
    case (phase_r)
      PH_TOP: begin
        if (data_byte == TermByte) begin
          tok_nxt.is_done = 1'b1;
        end else begin
          row_nxt   = RowW'(data_byte);
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        left_nxt  = data_byte;
        phase_nxt = PH_PAD1;
      end
      PH_PAD1: begin
        phase_nxt = (left_r == '0) ? PH_PAD2 : PH_PIX;
      end
      PH_PIX: begin
        tok_nxt.is_pix = 1'b1;
        row_nxt        = row_r + 1'b1;
        left_nxt       = left_r - 1'b1;
        if (left_r == ByteW'(1)) phase_nxt = PH_PAD2;
      end
      default: begin
        phase_nxt = PH_TOP;
      end
    endcase
  end

  // Hold parser state and the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TOP;
      row_r       <= '0;
      left_r      <= '0;
      tok_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        row_r   <= row_nxt;
        left_r  <= left_nxt;
      end
      if (load) tok_valid_r <= accept;
    end
    if (load) tok_r <= tok_nxt;
  end

  assign tok_valid = tok_valid_r;
  assign tok       = tok_r;

endmodule

>>> rtl/core/cpd_addr.sv
// Range checks, address arithmetic and the result register.
`timescale 1ns / 1ps
module cpd_addr
  import cpd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = CpdScreenWidth,
  parameter int SCREEN_HEIGHT = CpdScreenHeight
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             tok_valid,
  input  cpd_tok_t         tok,
  input  cpd_cfg_t         cfg,
  output logic             out_valid,
  output logic             write_enable,
  output logic [AddrW-1:0] write_address,
  output logic [ByteW-1:0] pixel_value,
  output logic             column_done,
  output logic             range_error
);

  localparam logic [16:0]      SwWide = 17'(SCREEN_WIDTH);
  localparam logic [16:0]      ShWide = 17'(SCREEN_HEIGHT);
  localparam logic [AddrW-1:0] SwAddr = AddrW'(SCREEN_WIDTH);

  logic             org_bad, col_bad, row_bad, x_bad, ok;
  logic [ColW-1:0]  dcol;
  logic [16:0]      row_sum, x_sum;
  logic [31:0]      prod;
  logic [AddrW-1:0] addr;

  logic             valid_r;
  logic             we_r, done_r, err_r;
  logic [AddrW-1:0] addr_r;
  logic [ByteW-1:0] pix_r;

  // Check origin, column and row against the screen
  always_comb begin
    org_bad = cfg.origin_x[OrgW-1] | cfg.origin_y[OrgW-1]
            | (({2'b0, cfg.origin_x[OrgW-2:0]} + 17'(cfg.picture_width)) > SwWide)
            | (({2'b0, cfg.origin_y[OrgW-2:0]} + 17'(cfg.picture_height)) > ShWide);
    col_bad = tok.col >= cfg.picture_width;
    dcol    = cfg.mirror_enable ? (cfg.picture_width - 1'b1 - tok.col) : tok.col;
    row_sum = {2'b0, cfg.origin_y[OrgW-2:0]} + 17'(tok.row);
    x_sum   = {2'b0, cfg.origin_x[OrgW-2:0]} + 17'(dcol);
    row_bad = row_sum >= ShWide;
    x_bad   = x_sum >= SwWide;
    ok      = !org_bad && !col_bad && !row_bad && !x_bad;
  end

  // Address keeps its low bits only
  assign prod = row_sum[AddrW-1:0] * SwAddr;
  assign addr = prod[AddrW-1:0] + x_sum[AddrW-1:0];

  // Load the result register when the output side moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= tok_valid;
    end
    if (advance) begin
      we_r   <= tok.is_pix && ok;
      err_r  <= tok.is_pix && !ok;
      done_r <= tok.is_done;
      addr_r <= (tok.is_pix && ok) ? addr : '0;
      pix_r  <= (tok.is_pix && ok) ? tok.data : '0;
    end
  end

  assign out_valid     = valid_r;
  assign write_enable  = we_r;
  assign write_address = addr_r;
  assign pixel_value   = pix_r;
  assign column_done   = done_r;
  assign range_error   = err_r;

endmodule

>>> rtl/core/column_post_patch_drawer.sv
// Top level of the column post drawer: config registers and pipeline flow.
// Each accepted byte passes the input register, then the result register,
// and yields one result. Throughput: one byte per cycle while out_stall
// is low; the address multiply-add sits in one stage.
// Reset (rst_n low, synchronous): parser waits for a top delta, row and
// post count clear, config registers return to zero, both stages empty.
`timescale 1ns / 1ps
module column_post_patch_drawer
  import cpd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = CpdScreenWidth,
  parameter int SCREEN_HEIGHT = CpdScreenHeight
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ColW-1:0]     in_source_column,
  input  logic [ByteW-1:0]    in_data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_write_enable,
  output logic [AddrW-1:0]    out_write_address,
  output logic [ByteW-1:0]    out_pixel_value,
  output logic                out_column_done,
  output logic                out_range_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cpd_cfg_t cfg_r;
  cpd_tok_t tok;
  logic     tok_valid;
  logic     advance, load, accept;

  // Result stage moves unless a held result is stalled
  assign advance  = !(out_valid && out_stall);
  assign load     = !tok_valid || advance;
  assign in_stall = !load;
  assign accept   = in_valid && load;
  assign cfg_ready = 1'b1;

  // Write config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:   cfg_r.origin_x       <= cfg_data;
        REG_ORIGIN_Y:   cfg_r.origin_y       <= cfg_data;
        REG_PIC_WIDTH:  cfg_r.picture_width  <= cfg_data[PicWW-1:0];
        REG_PIC_HEIGHT: cfg_r.picture_height <= cfg_data[PicHW-1:0];
        REG_MIRROR:     cfg_r.mirror_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cpd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .load          (load),
    .source_column (in_source_column),
    .data_byte     (in_data_byte),
    .tok_valid     (tok_valid),
    .tok           (tok)
  );

  cpd_addr #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_addr (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .tok_valid     (tok_valid),
    .tok           (tok),
    .cfg           (cfg_r),
    .out_valid     (out_valid),
    .write_enable  (out_write_enable),
    .write_address (out_write_address),
    .pixel_value   (out_pixel_value),
    .column_done   (out_column_done),
    .range_error   (out_range_error)
  );

endmodule

>>> rtl/core/cpd_checker.sv
// Port-level checks for the column post drawer, bound to the top level.
`timescale 1ns / 1ps
module cpd_checker
  import cpd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_write_enable,
  input logic [AddrW-1:0] out_write_address,
  input logic [ByteW-1:0] out_pixel_value,
  input logic             out_column_done,
  input logic             out_range_error
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_write_address)
      && $stable(out_pixel_value) && $stable(out_write_enable))
    else $error("stalled result changed");

  // A write is never also a terminator or an error
  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> !out_range_error && !out_column_done)
    else $error("write flagged as done or error");

  // Items without a write carry zero address and pixel
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_write_address == '0 && out_pixel_value == '0)
    else $error("non-write item has nonzero payload");

  // Accepted item passes the input register and reaches the output when not stalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind column_post_patch_drawer cpd_checker u_cpd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_write_enable  (out_write_enable),
  .out_write_address (out_write_address),
  .out_pixel_value   (out_pixel_value),
  .out_column_done   (out_column_done),
  .out_range_error   (out_range_error)
);

>>> tb/column_post_patch_drawer_tb.sv
// Self-checking testbench for the column post drawer: streams post columns and checks every write.
`timescale 1ns / 1ps
module column_post_patch_drawer_tb;
  import cpd_pkg::*;

  // Where the parser stands within a post
  typedef enum logic [2:0] {
    AT_DELTA,
    AT_LENGTH,
    AT_LEAD_PAD,
    AT_PIXEL,
    AT_TAIL_PAD
  } post_phase_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] write_address;
    logic [ByteW-1:0] pixel_value;
    logic             column_done;
    logic             range_error;
  } pixel_write_t;

  // Tracks the drawer's registers and parser, and holds the writes still owed
  class post_draw_scoreboard;
    logic [OrgW-1:0]  org_x;
    logic [OrgW-1:0]  org_y;
    logic [PicWW-1:0] pic_w;
    logic [PicHW-1:0] pic_h;
    logic             mirror;
    post_phase_t      phase;
    logic [RowW-1:0]  row;
    logic [ByteW-1:0] left;
    pixel_write_t     owed_writes[$];
    int               mismatches;

    function new();
      org_x      = '0;
      org_y      = '0;
      pic_w      = '0;
      pic_h      = '0;
      mirror     = 1'b0;
      phase      = AT_DELTA;
      row        = '0;
      left       = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_ORIGIN_X:   org_x = val;
        REG_ORIGIN_Y:   org_y = val;
        REG_PIC_WIDTH:  pic_w = val[PicWW-1:0];
        REG_PIC_HEIGHT: pic_h = val[PicHW-1:0];
        REG_MIRROR:     mirror = val[0];
        default: ;
      endcase
    endfunction

    // Advance the parser by one byte and return the write it causes
    function pixel_write_t draw_byte(logic [ColW-1:0] col, logic [ByteW-1:0] data);
      pixel_write_t res;
      int ox, oy, pw, ph, c, dcol, y, x;
      bit ok;
      res = '0;
      case (phase)
        AT_DELTA: begin
          if (data == TermByte) begin
            res.column_done = 1'b1;
          end else begin
            row   = RowW'(data);
            phase = AT_LENGTH;
          end
        end
        AT_LENGTH: begin
          left  = data;
          phase = AT_LEAD_PAD;
        end
        AT_LEAD_PAD: phase = (left == '0) ? AT_TAIL_PAD : AT_PIXEL;
        AT_PIXEL: begin
          ox = $signed(org_x);
          oy = $signed(org_y);
          pw = pic_w;
          ph = pic_h;
          c  = col;
          ok = !(ox < 0 || oy < 0 || ox + pw > CpdScreenWidth || oy + ph > CpdScreenHeight);
          if (c >= pw) ok = 1'b0;
          if (ok) begin
            dcol = mirror ? pw - 1 - c : c;
            y    = oy + int'(row);
            x    = ox + dcol;
            if (y >= CpdScreenHeight || x < 0 || x >= CpdScreenWidth) begin
              ok = 1'b0;
            end else begin
              res.write_enable  = 1'b1;
              res.write_address = AddrW'(y * CpdScreenWidth + x);
              res.pixel_value   = data;
            end
          end
          res.range_error = !ok;
          row  = row + 1'b1;
          left = left - 1'b1;
          if (left == '0) phase = AT_TAIL_PAD;
        end
        default: phase = AT_DELTA;
      endcase
      return res;
    endfunction

    function void note_byte(logic [ColW-1:0] col, logic [ByteW-1:0] data);
      owed_writes.push_back(draw_byte(col, data));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_write(pixel_write_t got);
      pixel_write_t want;
      if (owed_writes.size() == 0) begin
        $error("result item arrived with nothing owed");
        mismatches++;
        return;
      end
      want = owed_writes.pop_front();
      compare_field("write_enable", want.write_enable, got.write_enable);
      compare_field("write_address", want.write_address, got.write_address);
      compare_field("pixel_value", want.pixel_value, got.pixel_value);
      compare_field("column_done", want.column_done, got.column_done);
      compare_field("range_error", want.range_error, got.range_error);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ColW-1:0]     in_source_column;
  logic [ByteW-1:0]    in_data_byte;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_write_enable;
  logic [AddrW-1:0]    out_write_address;
  logic [ByteW-1:0]    out_pixel_value;
  logic                out_column_done;
  logic                out_range_error;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  post_draw_scoreboard sb = new();
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int bytes_sent   = 0;

  column_post_patch_drawer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_source_column  (in_source_column),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_enable  (out_write_enable),
    .out_write_address (out_write_address),
    .out_pixel_value   (out_pixel_value),
    .out_column_done   (out_column_done),
    .out_range_error   (out_range_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Check every accepted result item
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_write({out_write_enable, out_write_address, out_pixel_value,
                      out_column_done, out_range_error});
  end

  // Offer one byte, idling first at random, and hold it until accepted
  task automatic send_byte(logic [ColW-1:0] col, logic [ByteW-1:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid         <= 1'b0;
      in_source_column <= ColW'($urandom);
      in_data_byte     <= ByteW'($urandom);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_source_column <= col;
    in_data_byte     <= data;
    do @(posedge clk); while (in_stall);
    sb.note_byte(col, data);
    bytes_sent++;
  endtask

  // Drop valid and wait until every owed write has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.owed_writes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // Reprogram all registers once the pipeline is empty
  task automatic load_setting(logic [OrgW-1:0] ox, logic [OrgW-1:0] oy, int w, int h, bit m);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_PIC_WIDTH, CfgDataW'(w));
    write_reg(REG_PIC_HEIGHT, CfgDataW'(h));
    write_reg(REG_MIRROR, CfgDataW'(m));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly columns inside the picture, now and then any index
  function automatic logic [ColW-1:0] pick_column();
    int w;
    w = sb.pic_w;
    if (w != 0 && $urandom_range(9) != 0) return ColW'($urandom_range(w - 1));
    return ColW'($urandom);
  endfunction

  // Send a well-formed column: a few posts, then the terminator
  task automatic send_column();
    logic [ColW-1:0] col;
    int posts, len, delta;
    col   = pick_column();
    posts = $urandom_range(3);
    for (int p = 0; p < posts; p++) begin
      delta = ($urandom_range(3) == 0) ? $urandom_range(254) : $urandom_range(int'(sb.pic_h));
      if (delta > 254) delta = 254;
      len = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(8);
      send_byte(col, ByteW'(delta));
      send_byte(col, ByteW'(len));
      send_byte(col, ByteW'($urandom));
      for (int i = 0; i < len; i++) begin
        // switch column mid-post now and then
        if ($urandom_range(19) == 0) col = pick_column();
        send_byte(col, ByteW'($urandom));
      end
      send_byte(col, ByteW'($urandom));
    end
    send_byte(col, TermByte);
  endtask

  // Throw in junk bytes, then feed bytes until the parser waits for a top delta
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_byte(pick_column(), ByteW'($urandom));
    while (sb.phase != AT_DELTA) send_byte(pick_column(), ByteW'($urandom));
  endtask

  initial begin
    int w, h, target, waited;
    bit paused;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_source_column = '0;
    in_data_byte     = '0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_ORIGIN_X;
    cfg_data         = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct  = 24;
    rx_stall_pct = 82;

    // Directed: screen edges, row off screen, empty post, bad column mid-post
    load_setting(16'd0, 16'd0, 320, 200, 1'b0);
    send_byte(9'd319, 8'd0);
    send_byte(9'd319, 8'd1);
    send_byte(9'd319, 8'h00);
    send_byte(9'd319, 8'hff);
    send_byte(9'd319, 8'h00);
    send_byte(9'd319, 8'd199);
    send_byte(9'd319, 8'd2);
    send_byte(9'd319, 8'h00);
    send_byte(9'd319, 8'h00);
    send_byte(9'd319, 8'haa);
    send_byte(9'd319, 8'h00);
    send_byte(9'd0, 8'd5);
    send_byte(9'd0, 8'd0);
    send_byte(9'd0, 8'h00);
    send_byte(9'd0, 8'h00);
    send_byte(9'd0, TermByte);
    send_byte(9'd3, 8'd0);
    send_byte(9'd3, 8'd1);
    send_byte(9'd3, 8'h00);
    send_byte(9'd320, 8'h55);
    send_byte(9'd3, 8'h00);
    send_byte(9'd3, TermByte);

    // Random: one register setting per pass, idling pattern by pass
    for (int s = 0; s < 10; s++) begin
      case (s)
        0: load_setting(16'd0, 16'd0, 320, 200, 1'b1);
        1: load_setting(16'h8000, 16'h7fff, 511, 255, 1'b0);
        2: load_setting(16'h7fff, 16'hffff, 0, 0, 1'b1);
        4: load_setting(16'd319, 16'd200, 1, 0, 1'b1);
        5: load_setting(OrgW'($urandom), OrgW'($urandom), $urandom_range(511),
                        $urandom_range(255), 1'($urandom_range(1)));
        default: begin
          w = $urandom_range(1, 320);
          h = $urandom_range(200);
          load_setting(OrgW'($urandom_range(320 - w)), OrgW'($urandom_range(200 - h)),
                       w, h, 1'($urandom_range(1)));
        end
      endcase
      if (s < 4) begin
        tx_idle_pct  = 24;
        rx_stall_pct = 82;
      end else if (s < 7) begin
        tx_idle_pct  = 82;
        rx_stall_pct = 24;
      end else begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      target = bytes_sent + 125;
      paused = 1'b0;
      while (bytes_sent < target) begin
        if ($urandom_range(9) == 0) send_noise();
        else send_column();
        // hold off once until every owed write has drained
        if (!paused && bytes_sent > target - 60) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    waited = 0;
    while (sb.owed_writes.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.owed_writes.size() != 0) begin
      $error("%0d result items never arrived", sb.owed_writes.size());
      sb.mismatches++;
    end
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> column_post_patch_drawer.f
rtl/core/cpd_pkg.sv
rtl/core/cpd_parser.sv
rtl/core/cpd_addr.sv
rtl/core/column_post_patch_drawer.sv
rtl/core/cpd_checker.sv
tb/column_post_patch_drawer_tb.sv
